FILE: src/fixed_slot_pool_allocator_core_assert.svh
// assertion helpers for the slot pool checker
`ifndef FIXED_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FSPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FSPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/fspa_pkg.sv
package fspa_pkg;

	// parameter defaults
	localparam int MAX_CHUNKS_DEF     = 16;
	localparam int MAX_FREE_SLOTS_DEF = 16384;
	localparam int LINK_BYTES_DEF     = 4;

	// fixed widths
	localparam int CFG_W     = 13;
	localparam int LIMIT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W    = 16;
	localparam int BYTES_W   = 17;
	localparam int STATUS_W  = 2;
	// rounded slot length can reach 8192
	localparam int RW        = CFG_W + 1;
	localparam int TAIL_GAP  = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0]   SLOT_LEN_RST    = 13'd16;
	localparam logic [CFG_W-1:0]   CHUNK_LEN_RST   = 13'd4096;
	localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RST = 5'd16;

	// input commands
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [BYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIVIDE,
		ST_CARVE,
		ST_POP,
		ST_FINISH
	} fspa_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic push;
		logic pop;
		logic div_start;
		logic carve;
		logic load_out;
	} fspa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_release;
		logic empty;
		logic can_take;
		logic div_done;
	} fspa_stat_t;

	// clamp a byte count to the result field
	function automatic logic [BYTES_W-1:0] fspa_sat(input logic [31:0] v);
		logic [BYTES_W-1:0] r;
		if (v > 32'(BYTES_MAX)) begin
			r = BYTES_MAX;
		end else begin
			r = v[BYTES_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: src/fixed_slot_pool_allocator_core.sv
// a result passes ST_DECIDE, ST_FINISH, the output register; an allocate that takes
// a chunk adds ST_DIVIDE (13-step slot count divider), ST_CARVE, ST_POP; beats are
// taken in ST_IDLE or ST_FINISH with a free output; at most one free list access each
// reset (arst_n, async, active low): no chunk held, free list empty, registers at
// their defaults; the free list memory is not cleared and needs no clearing pass
module fixed_slot_pool_allocator_core import fspa_pkg::*; #(
	parameter int MAX_CHUNKS     = MAX_CHUNKS_DEF,
	parameter int MAX_FREE_SLOTS = MAX_FREE_SLOTS_DEF,
	parameter int LINK_BYTES     = LINK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    address,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    slot_address,
	output logic [STATUS_W-1:0]  status,
	output logic [BYTES_W-1:0]   free_bytes,
	output logic [BYTES_W-1:0]   total_bytes
);

	fspa_cmd_t  cmd;
	fspa_stat_t stat;

	// sequencer
	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// free list, chunk carving and result datapath
	fspa_dpath #(
		.MAX_CHUNKS     (MAX_CHUNKS),
		.MAX_FREE_SLOTS (MAX_FREE_SLOTS),
		.LINK_BYTES     (LINK_BYTES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.address      (address),
		.cmd          (cmd),
		.stat         (stat),
		.slot_address (slot_address),
		.status       (status),
		.free_bytes   (free_bytes),
		.total_bytes  (total_bytes)
	);

endmodule

FILE: src/fspa_ram.sv
module fspa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/fspa_div.sv
module fspa_div import fspa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CFG_W-1:0] dividend,
	input  logic [RW-1:0]    divisor,
	output logic             done,
	output logic [CFG_W-1:0] quotient
);

	localparam int CNT_W = $clog2(CFG_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] quo_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    divsr_q;
	logic [RW-1:0]    shifted;
	logic [RW:0]      trial;

	// one restoring step per cycle, msb first
	assign shifted = {rem_q[RW-2:0], quo_q[CFG_W-1]};
	assign trial   = {1'b0, shifted} - {1'b0, divsr_q};
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(CFG_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q   <= dividend;
			rem_q   <= '0;
			divsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[RW]) begin
				rem_q <= trial[RW-1:0];
				quo_q <= {quo_q[CFG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[CFG_W-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: src/fspa_dpath.sv
module fspa_dpath import fspa_pkg::*; #(
	parameter int MAX_CHUNKS     = MAX_CHUNKS_DEF,
	parameter int MAX_FREE_SLOTS = MAX_FREE_SLOTS_DEF,
	parameter int LINK_BYTES     = LINK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    address,
	input  fspa_cmd_t            cmd,
	output fspa_stat_t           stat,
	output logic [ADDR_W-1:0]    slot_address,
	output logic [STATUS_W-1:0]  status,
	output logic [BYTES_W-1:0]   free_bytes,
	output logic [BYTES_W-1:0]   total_bytes
);

	localparam int AW    = $clog2(MAX_FREE_SLOTS);
	localparam int CW    = $clog2(MAX_FREE_SLOTS + 1);
	localparam int KW    = $clog2(MAX_CHUNKS + 1);
	localparam int FB_MW = CW + RW;
	localparam int TB_MW = KW + CFG_W;
	localparam int PM_W  = AW + RW;
	localparam logic [CW-1:0]     STACK_MAX = CW'(MAX_FREE_SLOTS);
	localparam logic [ADDR_W-1:0] LINK_OFS  = ADDR_W'(LINK_BYTES);

	logic [CFG_W-1:0]    slot_len_q;
	logic [CFG_W-1:0]    chunk_len_q;
	logic [LIMIT_W-1:0]  chunk_limit_q;
	logic                cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lazy_q;
	logic [KW-1:0]       chunks_q;
	logic [ADDR_W-1:0]   base_q;
	logic [RW-1:0]       step_q;
	logic                zero_q;
	logic                granted_s1;
	logic                lazy_hit_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [ADDR_W-1:0]   prod_s1;
	logic [ADDR_W-1:0]   slot_address_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTES_W-1:0]  free_bytes_q;
	logic [BYTES_W-1:0]  total_bytes_q;

	logic [RW-1:0]       r_cur;
	logic [RW:0]         need;
	logic                zero_case;
	logic [CFG_W-1:0]    div_dividend;
	logic                div_done;
	logic [CFG_W-1:0]    div_quo;
	logic [RW:0]         slots_n;
	logic [CW-1:0]       slots_eff;
	logic [CW-1:0]       pos;
	logic                full;
	logic                can_take;
	logic [PM_W-1:0]     pop_mul;
	logic [FB_MW-1:0]    fb_mul;
	logic [TB_MW-1:0]    tb_mul;
	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_rdata;
	logic [ADDR_W-1:0]   slot_sel;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_len_q    <= SLOT_LEN_RST;
			chunk_len_q   <= CHUNK_LEN_RST;
			chunk_limit_q <= CHUNK_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_LEN:    slot_len_q    <= cfg_data;
				REG_CHUNK_LEN:   chunk_len_q   <= cfg_data;
				REG_CHUNK_LIMIT: chunk_limit_q <= cfg_data[LIMIT_W-1:0];
				default:         ;
			endcase
		end
	end

	// slot geometry of a new chunk
	assign r_cur        = ({1'b0, slot_len_q} + RW'(3)) & ~RW'(3);
	assign need         = {1'b0, r_cur} + (RW+1)'(TAIL_GAP) + (RW+1)'(LINK_BYTES);
	assign zero_case    = (r_cur == '0) || ({2'b00, chunk_len_q} < need);
	assign div_dividend = CFG_W'({2'b00, chunk_len_q} - need);

	// slot count of a chunk: (span / step) + 1
	fspa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (r_cur),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign slots_n = {2'b00, div_quo} + (RW+1)'(1);
	always_comb begin
		if (zero_q) begin
			slots_eff = '0;
		end else if (32'(slots_n) > 32'(MAX_FREE_SLOTS)) begin
			slots_eff = STACK_MAX;
		end else begin
			slots_eff = CW'(slots_n);
		end
	end

	// stack top and chunk products
	assign pos      = count_q - 1'b1;
	assign full     = (count_q == STACK_MAX);
	assign can_take = (32'(chunks_q) < 32'(chunk_limit_q)) &&
		(32'(chunks_q) < 32'(MAX_CHUNKS));
	assign pop_mul  = PM_W'(pos[AW-1:0]) * PM_W'(step_q);
	assign fb_mul   = FB_MW'(count_q) * FB_MW'(r_cur);
	assign tb_mul   = TB_MW'(chunks_q) * TB_MW'(chunk_len_q);

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= command;
			addr_q <= address;
		end
	end

	// stack pointer, carved region bound and chunk count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			lazy_q   <= '0;
			chunks_q <= '0;
			zero_q   <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				zero_q <= zero_case;
			end
			if (cmd.push && !full) begin
				count_q <= count_q + 1'b1;
				if (count_q < lazy_q) begin
					lazy_q <= count_q;
				end
			end else if (cmd.pop && (count_q != '0)) begin
				count_q <= pos;
			end else if (cmd.carve) begin
				count_q  <= slots_eff;
				lazy_q   <= slots_eff;
				chunks_q <= chunks_q + 1'b1;
			end
		end
	end

	// carved chunk base and step, taken when the chunk is claimed
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			base_q <= ADDR_W'(tb_mul);
			step_q <= r_cur;
		end
	end

	// per-item result state
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			granted_s1  <= 1'b0;
			lazy_hit_s1 <= 1'b0;
			status_s1   <= full ? STATUS_OVERFLOW : STATUS_OK;
		end else if (cmd.pop) begin
			granted_s1  <= (count_q != '0);
			lazy_hit_s1 <= (pos < lazy_q);
			prod_s1     <= pop_mul[ADDR_W-1:0];
			status_s1   <= (count_q != '0) ? STATUS_OK : STATUS_NO_SPACE;
		end
	end

	// free list storage
	assign ram_we = cmd.push && !full;
	assign ram_re = cmd.pop && (count_q != '0);

	fspa_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_FREE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (addr_q),
		.re    (ram_re),
		.raddr (pos[AW-1:0]),
		.rdata (ram_rdata)
	);

	// entries still in the carved region are computed, not stored
	always_comb begin
		if (!granted_s1) begin
			slot_sel = '0;
		end else if (lazy_hit_s1) begin
			slot_sel = base_q + LINK_OFS + prod_s1;
		end else begin
			slot_sel = ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slot_address_q <= slot_sel;
			status_q       <= status_s1;
			free_bytes_q   <= fspa_sat(32'(fb_mul));
			total_bytes_q  <= fspa_sat(32'(tb_mul));
		end
	end

	assign slot_address = slot_address_q;
	assign status       = status_q;
	assign free_bytes   = free_bytes_q;
	assign total_bytes  = total_bytes_q;

	assign stat.is_release = (cmd_q == CMD_RELEASE);
	assign stat.empty      = (count_q == '0);
	assign stat.can_take   = can_take;
	assign stat.div_done   = div_done;

endmodule

FILE: src/fspa_ctrl.sv
module fspa_ctrl import fspa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  fspa_stat_t stat,
	output fspa_cmd_t  cmd
);

	fspa_state_t state_q;
	fspa_state_t state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        accept;
	logic        carve_now;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) || ((state_q == ST_FINISH) && out_free));
	assign accept    = in_valid && !in_stall;
	assign carve_now = !stat.is_release && stat.empty && stat.can_take;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = carve_now ? ST_DIVIDE : ST_FINISH;
			end
			ST_DIVIDE: begin
				if (stat.div_done) begin
					state_d = ST_CARVE;
				end
			end
			ST_CARVE: begin
				state_d = ST_POP;
			end
			ST_POP: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = accept ? ST_DECIDE : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.push      = (state_q == ST_DECIDE) && stat.is_release;
		cmd.div_start = (state_q == ST_DECIDE) && carve_now;
		cmd.pop       = ((state_q == ST_DECIDE) && !stat.is_release && !carve_now) ||
			(state_q == ST_POP);
		cmd.carve     = (state_q == ST_CARVE);
		cmd.load_out  = (state_q == ST_FINISH) && out_free;
	end

	// state and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/fspa_checker.sv
`include "fixed_slot_pool_allocator_core_assert.svh"

module fspa_checker import fspa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [ADDR_W-1:0]   slot_address,
	input logic [STATUS_W-1:0] status,
	input logic [BYTES_W-1:0]  free_bytes
);

	// one beat in flight: the input stalls right after a beat is taken
	`FSPA_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second beat taken while busy")

	// a failed request never grants a slot
	`FSPA_ASSERT_IMP(a_fail_no_slot, out_valid && (status != STATUS_OK), slot_address == '0, "slot granted on failure")

	// free bytes are whole rounded slots unless clamped
	`FSPA_ASSERT_IMP(a_free_aligned, out_valid, (free_bytes[1:0] == 2'b00) || (free_bytes == BYTES_MAX), "free bytes not a multiple of four")

	// a stalled result holds
	`FSPA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(slot_address) && $stable(status), "stalled result changed")

endmodule

bind fixed_slot_pool_allocator_core fspa_checker u_fspa_checker (.*);

FILE: test/fspa_pool_checker.sv
module fspa_pool_checker import fspa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    address,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [ADDR_W-1:0]    slot_address,
	input  logic [STATUS_W-1:0]  status,
	input  logic [BYTES_W-1:0]   free_bytes,
	input  logic [BYTES_W-1:0]   total_bytes,
	output int                   fail_count,
	output int                   due_count,
	output int                   stack_depth,
	output int                   chunks_held,
	output int                   grant_count,
	output int                   refusal_count,
	output int                   overflow_count
);

	// one predicted result beat
	typedef struct {
		logic [ADDR_W-1:0]   slot;
		logic [STATUS_W-1:0] code;
		logic [BYTES_W-1:0]  free_b;
		logic [BYTES_W-1:0]  total_b;
	} pool_result_t;

	pool_result_t      due_results[$];
	logic [ADDR_W-1:0] free_list [MAX_FREE_SLOTS_DEF];
	int unsigned       list_depth;
	int unsigned       chunks_now;
	logic [CFG_W-1:0]  slot_reg;
	logic [CFG_W-1:0]  chunk_reg;
	logic [LIMIT_W-1:0] limit_reg;
	int                errors;
	int                grants;
	int                refusals;
	int                overflows;

	function automatic int unsigned rounded_len();
		return (32'(slot_reg) + 32'd3) & ~32'd3;
	endfunction

	function automatic logic [BYTES_W-1:0] clamp_bytes(input longint unsigned v);
		if (v > 64'(BYTES_MAX)) begin
			return BYTES_MAX;
		end
		return v[BYTES_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (errors < 100) begin
			$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
		errors++;
	endtask

	// entries past the free list depth are dropped
	task automatic push_free(input int unsigned a);
		if (list_depth < MAX_FREE_SLOTS_DEF) begin
			free_list[list_depth] = a[ADDR_W-1:0];
			list_depth++;
		end
	endtask

	// take the next chunk and push its slots in ascending order
	task automatic carve_chunk();
		int unsigned r;
		int unsigned base;
		int unsigned off;
		r = rounded_len();
		base = chunks_now * 32'(chunk_reg);
		chunks_now++;
		if (r == 0 || 32'(chunk_reg) < r + TAIL_GAP) begin
			return;
		end
		for (off = LINK_BYTES_DEF; off <= 32'(chunk_reg) - r - TAIL_GAP; off += r) begin
			push_free(base + off);
		end
	endtask

	// advance the pool by one command beat and queue its result
	task automatic pool_step(input logic cmd, input logic [ADDR_W-1:0] addr);
		pool_result_t res;
		int unsigned  lim;
		res.slot = '0;
		res.code = STATUS_OK;
		lim = (32'(limit_reg) < MAX_CHUNKS_DEF) ? 32'(limit_reg) : MAX_CHUNKS_DEF;
		if (cmd == CMD_ALLOC) begin
			if (list_depth == 0 && chunks_now < lim) begin
				carve_chunk();
			end
			if (list_depth > 0) begin
				list_depth--;
				res.slot = free_list[list_depth];
				grants++;
			end else begin
				res.code = STATUS_NO_SPACE;
				refusals++;
			end
		end else if (list_depth < MAX_FREE_SLOTS_DEF) begin
			push_free(32'(addr));
		end else begin
			res.code = STATUS_OVERFLOW;
			overflows++;
		end
		res.free_b = clamp_bytes(64'(list_depth) * 64'(rounded_len()));
		res.total_b = clamp_bytes(64'(chunks_now) * 64'(chunk_reg));
		due_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			due_results.delete();
			list_depth = 0;
			chunks_now = 0;
			slot_reg = SLOT_LEN_RST;
			chunk_reg = CHUNK_LEN_RST;
			limit_reg = CHUNK_LIMIT_RST;
			errors = 0;
			grants = 0;
			refusals = 0;
			overflows = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SLOT_LEN: begin
						slot_reg = cfg_data;
					end
					REG_CHUNK_LEN: begin
						chunk_reg = cfg_data;
					end
					REG_CHUNK_LIMIT: begin
						limit_reg = cfg_data[LIMIT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// command beat
			if (in_valid && !in_stall) begin
				pool_step(command, address);
			end
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing due", slot_address, 0);
				end else begin
					want = due_results.pop_front();
					if (slot_address !== want.slot) begin
						report_mismatch("slot_address", slot_address, want.slot);
					end
					if (status !== want.code) begin
						report_mismatch("status", status, want.code);
					end
					if (free_bytes !== want.free_b) begin
						report_mismatch("free_bytes", free_bytes, want.free_b);
					end
					if (total_bytes !== want.total_b) begin
						report_mismatch("total_bytes", total_bytes, want.total_b);
					end
				end
			end
		end
		fail_count <= errors;
		due_count <= due_results.size();
		stack_depth <= list_depth;
		chunks_held <= chunks_now;
		grant_count <= grants;
		refusal_count <= refusals;
		overflow_count <= overflows;
	end

endmodule

FILE: test/tb_fixed_slot_pool_allocator_core.sv
module tb_fixed_slot_pool_allocator_core;
	import fspa_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SLOT_LEN;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_ALLOC;
	logic [ADDR_W-1:0]    address = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ADDR_W-1:0]    slot_address;
	logic [STATUS_W-1:0]  status;
	logic [BYTES_W-1:0]   free_bytes;
	logic [BYTES_W-1:0]   total_bytes;

	int fail_count;
	int due_count;
	int stack_depth;
	int chunks_held;
	int grant_count;
	int refusal_count;
	int overflow_count;

	// sender and register bookkeeping
	bit          valid_on = 1'b0;
	bit          steady = 1'b0;
	int          burst_left = 0;
	int          beats_sent = 0;
	int          settings_used = 0;
	int unsigned cur_slot = 16;
	int unsigned cur_chunk = 4096;
	int unsigned held = 0;

	// receiver stall pattern
	int stall_mode = 0;
	int stall_left = 0;

	fixed_slot_pool_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot_address (slot_address),
		.status       (status),
		.free_bytes   (free_bytes),
		.total_bytes  (total_bytes)
	);

	fspa_pool_checker mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.address        (address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_address   (slot_address),
		.status         (status),
		.free_bytes     (free_bytes),
		.total_bytes    (total_bytes),
		.fail_count     (fail_count),
		.due_count      (due_count),
		.stack_depth    (stack_depth),
		.chunks_held    (chunks_held),
		.grant_count    (grant_count),
		.refusal_count  (refusal_count),
		.overflow_count (overflow_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stall modes change at random intervals, no stall among them
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 1) == 0);
			end
			default: begin
				out_stall <= ((stall_left % 5) < 2);
			end
		endcase
	end

	// drive one command beat and hold it until accepted; gaps fall between bursts
	task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] addr);
		int gap;
		in_valid <= 1'b1;
		valid_on = 1'b1;
		command <= cmd;
		address <= addr;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				valid_on = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic alloc_beat();
		send_beat(CMD_ALLOC, ADDR_W'($urandom));
	endtask

	task automatic release_beat(input logic [ADDR_W-1:0] addr);
		send_beat(CMD_RELEASE, addr);
	endtask

	// hold off until every result is back, then let the block go quiet
	task automatic settle();
		if (valid_on) begin
			in_valid <= 1'b0;
			valid_on = 1'b0;
		end
		do @(posedge clk); while (due_count != 0);
		repeat (24) @(posedge clk);
	endtask

	// write all three registers on consecutive edges
	task automatic set_regs(input int unsigned slot, input int unsigned chunk,
			input int unsigned lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_SLOT_LEN;
		cfg_data <= CFG_W'(slot);
		@(posedge clk);
		cfg_index <= REG_CHUNK_LEN;
		cfg_data <= CFG_W'(chunk);
		@(posedge clk);
		cfg_index <= REG_CHUNK_LIMIT;
		cfg_data <= CFG_W'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_slot = slot;
		cur_chunk = chunk;
		settings_used++;
	endtask

	// mostly addresses that look like real slots, some anywhere
	function automatic logic [ADDR_W-1:0] pick_release();
		int unsigned r;
		int unsigned k;
		int unsigned j;
		r = (cur_slot + 3) & ~32'd3;
		if (r == 0 || cur_chunk < r + 8 || $urandom_range(0, 3) == 0) begin
			return ADDR_W'($urandom);
		end
		k = $urandom_range(0, held + 1);
		j = $urandom_range(0, (cur_chunk - r - 8) / r);
		return ADDR_W'(k * cur_chunk + LINK_BYTES_DEF + j * r);
	endfunction

	initial begin
		int unsigned s_len;
		int unsigned c_len;
		int unsigned lim;
		int          alloc_pct;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// register values after reset, address extremes
		release_beat(16'hFFFF);
		release_beat(16'h0000);
		send_beat(CMD_ALLOC, 16'h0000);
		send_beat(CMD_ALLOC, 16'hFFFF);

		// chunk limit of zero never takes a chunk
		settle();
		set_regs(0, 12, 0);
		send_beat(CMD_ALLOC, 16'h5555);
		release_beat(16'hAAAA);
		send_beat(CMD_ALLOC, 16'h0000);

		// zero slot length: chunks counted but empty, then the limit is hit
		settle();
		set_regs(0, 8191, 2);
		repeat (3) send_beat(CMD_ALLOC, 16'h0000);

		// slot larger than the chunk, limit above the hard cap
		settle();
		set_regs(8191, 8191, 31);
		alloc_beat();

		// smallest chunk that holds a single slot
		settle();
		set_regs(1, 12, 31);
		alloc_beat();
		release_beat(16'hFFFF);
		release_beat(16'h8000);
		alloc_beat();
		alloc_beat();

		// slot that just misses fitting, then one that just fits
		settle();
		set_regs(4092, 4096, 16);
		alloc_beat();
		settle();
		set_regs(4085, 4096, 16);
		alloc_beat();
		release_beat(16'h0001);
		alloc_beat();

		// random phases, each with its own register setting
		for (int p = 0; p < 8; p++) begin
			settle();
			held = chunks_held;
			case ($urandom_range(0, 7))
				0: s_len = 0;
				1: s_len = 8191;
				2: s_len = $urandom_range(0, 8191);
				3: s_len = $urandom_range(4085, 4096);
				default: s_len = $urandom_range(1, 64);
			endcase
			case ($urandom_range(0, 7))
				0: c_len = $urandom_range(0, 11);
				1: c_len = 8191;
				2: c_len = $urandom_range(0, 8191);
				3: c_len = 4096;
				default: c_len = $urandom_range(12, 512);
			endcase
			// ration chunks, since none are ever given back
			case ($urandom_range(0, 5))
				0: lim = 0;
				1: lim = 31;
				2: lim = held;
				default: lim = held + $urandom_range(1, 2);
			endcase
			if (p == 0) begin
				s_len = $urandom_range(1, 64);
				c_len = $urandom_range(64, 512);
				lim = held + 2;
			end
			set_regs(s_len, c_len, lim);
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: alloc_pct = 30;
				1: alloc_pct = 50;
				2: alloc_pct = 70;
				default: alloc_pct = 85;
			endcase
			for (int k = 0; k < 238; k++) begin
				if (k == 119 && $urandom_range(0, 1) == 1) begin
					settle();
				end
				if ($urandom_range(1, 100) <= alloc_pct) begin
					alloc_beat();
				end else begin
					release_beat(pick_release());
				end
			end
		end

		// a run of releases so the list holds plenty of entries
		settle();
		set_regs(1, 8191, 16);
		held = chunks_held;
		steady = 1'b1;
		repeat (24) release_beat(pick_release());

		// longest slot on a well filled list saturates free_bytes
		settle();
		set_regs(8191, 8191, 16);
		alloc_beat();
		alloc_beat();
		repeat (3) release_beat(ADDR_W'($urandom));

		settle();
		$display("covered %0d beats over %0d register settings, %0d chunks carved",
			beats_sent, settings_used, chunks_held);
		$display("grants %0d, out of space %0d, free list overflows %0d, final depth %0d",
			grant_count, refusal_count, overflow_count, stack_depth);
		if (fail_count == 0 && due_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hang guard
	initial begin
		#10000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/fspa_pkg.sv
src/fspa_ram.sv
src/fspa_div.sv
src/fspa_dpath.sv
src/fspa_ctrl.sv
src/fixed_slot_pool_allocator_core.sv
src/fspa_checker.sv
test/fspa_pool_checker.sv
test/tb_fixed_slot_pool_allocator_core.sv
